>>> src/fswp_pkg.sv
// ----------------------------------------------------------------------------
// fswp_pkg: flash sector write planner shared definitions
// Field widths, default geometry and the action codes of the planner.
// ----------------------------------------------------------------------------
package fswp_pkg;

	// address width of the flash byte address field
	localparam int ADDRESS_BITS = 17;

	// transaction field widths
	localparam int BYTE_W    = 8;
	localparam int SECTOR_W  = 3;
	localparam int ACTION_W  = 2;
	localparam int PAGE_W    = 10;
	localparam int COUNT_W   = 8;

	// default flash geometry (powers of two)
	localparam int SECTOR_BYTES_DEF     = 16384;
	localparam int PAGE_BYTES_DEF       = 128;
	localparam int PAGES_PER_SECTOR_DEF = 128;

	// decision for one sector chunk
	typedef enum logic [ACTION_W-1:0] {
		ACT_SKIP    = 2'd0,
		ACT_PROGRAM = 2'd1,
		ACT_ERASE   = 2'd2
	} action_t;

endpackage

>>> src/flash_sector_write_planner.sv
// Path: a closing byte's decision passes the input and result registers.
// Throughput: one byte per cycle; input register and result register are parted by
// a single pass of compare and page arithmetic, so in_stall only rises when a held
// decision sits under out_stall and the waiting byte closes a chunk.
// Reset: arst_n clears both valid bits and the open chunk (flags and start offset).
// ----------------------------------------------------------------------------
// flash_sector_write_planner
// Gathers per-sector change and erase flags over a byte stream and emits one
// skip / program / erase decision at the end of every sector chunk.
// ----------------------------------------------------------------------------
module flash_sector_write_planner
	import fswp_pkg::*;
#(
	parameter int SECTOR_BYTES     = SECTOR_BYTES_DEF,
	parameter int PAGE_BYTES       = PAGE_BYTES_DEF,
	parameter int PAGES_PER_SECTOR = PAGES_PER_SECTOR_DEF
) (
	input  logic                    clk,
	input  logic                    arst_n,
	// byte transactions
	input  logic                    in_valid,
	output logic                    in_stall,
	input  logic [ADDRESS_BITS-1:0] dev_address,
	input  logic [BYTE_W-1:0]       current_byte,
	input  logic [BYTE_W-1:0]       new_byte,
	input  logic                    last_byte,
	// decision transactions
	output logic                    out_valid,
	input  logic                    out_stall,
	output logic [SECTOR_W-1:0]     sector_index,
	output logic [ACTION_W-1:0]     action,
	output logic [PAGE_W-1:0]       first_page,
	output logic [COUNT_W-1:0]      page_count
);

	localparam int OFF_W    = $clog2(SECTOR_BYTES);
	localparam int PG_SHIFT = $clog2(PAGE_BYTES);
	localparam int SECN_W   = ADDRESS_BITS - OFF_W;

	localparam logic [OFF_W-1:0]   OFF_LAST    = {OFF_W{1'b1}};
	localparam logic [PAGE_W-1:0]  PPS_PAGE    = PAGE_W'(PAGES_PER_SECTOR);
	localparam logic [COUNT_W-1:0] PPS_COUNT   = COUNT_W'(PAGES_PER_SECTOR);
	localparam logic [OFF_W-1:0]   ONE_OFF     = OFF_W'(1);

	// input register
	logic                    valid_s1;
	logic [ADDRESS_BITS-1:0] addr_s1;
	logic [BYTE_W-1:0]       cur_s1;
	logic [BYTE_W-1:0]       new_s1;
	logic                    last_s1;

	// open chunk state
	logic                    chunk_open_q;
	logic [OFF_W-1:0]        chunk_start_q;
	logic                    write_seen_q;
	logic                    erase_seen_q;

	// result register
	logic                    out_valid_q;
	logic [SECTOR_W-1:0]     sector_q;
	action_t                 action_q;
	logic [PAGE_W-1:0]       first_page_q;
	logic [COUNT_W-1:0]      page_count_q;

	// single-pass decision logic
	logic                    in_take;
	logic                    out_ready;
	logic                    s1_adv;
	logic [OFF_W-1:0]        off_c;
	logic [SECN_W-1:0]       sector_c;
	logic                    close_c;
	logic [OFF_W-1:0]        start_c;
	logic [OFF_W-1:0]        start_clamp_c;
	logic                    write_c;
	logic                    erase_c;
	logic [OFF_W-1:0]        start_pg_c;
	logic [OFF_W-1:0]        end_pg_c;
	logic [PAGE_W-1:0]       sector_page_c;
	action_t                 action_c;
	logic [PAGE_W-1:0]       first_page_c;
	logic [COUNT_W-1:0]      page_count_c;

	// handshake
	assign out_ready = !out_valid_q || !out_stall;
	assign s1_adv    = valid_s1 && (!close_c || out_ready);
	assign in_stall  = valid_s1 && !s1_adv;
	assign in_take   = in_valid && !in_stall;

	// split address, merge byte into running flags
	always_comb begin
		off_c         = addr_s1[OFF_W-1:0];
		sector_c      = addr_s1[ADDRESS_BITS-1:OFF_W];
		close_c       = last_s1 || (off_c == OFF_LAST);
		start_c       = chunk_open_q ? chunk_start_q : off_c;
		write_c       = (chunk_open_q && write_seen_q) || (cur_s1 != new_s1);
		erase_c       = (chunk_open_q && erase_seen_q) || ((cur_s1 & new_s1) != new_s1);
		start_clamp_c = (start_c > off_c) ? off_c : start_c;
		start_pg_c    = start_clamp_c >> PG_SHIFT;
		end_pg_c      = off_c >> PG_SHIFT;
		sector_page_c = PAGE_W'(PAGE_W'(sector_c) * PPS_PAGE);
	end

	// decision
	always_comb begin
		if (!write_c) begin
			action_c     = ACT_SKIP;
			first_page_c = '0;
			page_count_c = '0;
		end else if (erase_c) begin
			action_c     = ACT_ERASE;
			first_page_c = sector_page_c;
			page_count_c = PPS_COUNT;
		end else begin
			action_c     = ACT_PROGRAM;
			first_page_c = sector_page_c + PAGE_W'(start_pg_c);
			page_count_c = COUNT_W'(end_pg_c - start_pg_c + ONE_OFF);
		end
	end

	// input register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_take) begin
			valid_s1 <= 1'b1;
		end else if (s1_adv) begin
			valid_s1 <= 1'b0;
		end
	end

	// input register payload
	always_ff @(posedge clk) begin
		if (in_take) begin
			addr_s1 <= dev_address;
			cur_s1  <= current_byte;
			new_s1  <= new_byte;
			last_s1 <= last_byte;
		end
	end

	// chunk state: cleared at chunk end, else carries the merged flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chunk_open_q  <= 1'b0;
			chunk_start_q <= '0;
			write_seen_q  <= 1'b0;
			erase_seen_q  <= 1'b0;
		end else if (s1_adv) begin
			if (close_c) begin
				chunk_open_q  <= 1'b0;
				chunk_start_q <= '0;
				write_seen_q  <= 1'b0;
				erase_seen_q  <= 1'b0;
			end else begin
				chunk_open_q  <= 1'b1;
				chunk_start_q <= start_c;
				write_seen_q  <= write_c;
				erase_seen_q  <= erase_c;
			end
		end
	end

	// result register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s1_adv && close_c) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	// result register payload
	always_ff @(posedge clk) begin
		if (s1_adv && close_c) begin
			sector_q     <= SECTOR_W'(sector_c);
			action_q     <= action_c;
			first_page_q <= first_page_c;
			page_count_q <= page_count_c;
		end
	end

	assign out_valid    = out_valid_q;
	assign sector_index = sector_q;
	assign action       = action_q;
	assign first_page   = first_page_q;
	assign page_count   = page_count_q;

	// a closing byte always leaves the chunk closed
	a_close_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(s1_adv && close_c) |=> !chunk_open_q)
		else $error("chunk still open after closing byte");

	// a skip decision carries no pages
	a_skip_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && action_q == ACT_SKIP) |-> (page_count_q == '0 && first_page_q == '0))
		else $error("skip decision with pages");

	// an erase decision programs the whole sector
	a_erase_full: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && action_q == ACT_ERASE) |-> (page_count_q == PPS_COUNT))
		else $error("erase decision with partial page count");

	// a held byte stays in the input register
	a_hold_s1: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !s1_adv) |=> (valid_s1 && $stable(addr_s1) && $stable(last_s1)))
		else $error("held byte lost from input register");

	// a new decision is only loaded when the result register is free
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(s1_adv && close_c) |-> out_ready)
		else $error("decision overwritten while stalled");

endmodule

>>> dv/tb_flash_sector_write_planner.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_flash_sector_write_planner: self-checking bench for the write planner
// Streams write requests as byte transactions, predicts the per-sector
// skip / program / erase decision for each one and checks every decision
// transaction field by field. Sender gaps and receiver stalls vary by phase.
// ----------------------------------------------------------------------------
module tb_flash_sector_write_planner
	import fswp_pkg::*;
();

	localparam int CYCLE_LIMIT = 200000;
	localparam int DRAIN_CYCLES = 10;

	typedef struct {
		logic [ADDRESS_BITS-1:0] addr;
		logic [BYTE_W-1:0]       cur;
		logic [BYTE_W-1:0]       nw;
		logic                    last;
	} byte_item_t;

	typedef struct {
		logic [SECTOR_W-1:0] sector;
		action_t             act;
		logic [PAGE_W-1:0]   first;
		logic [COUNT_W-1:0]  count;
	} decision_t;

	logic                    clk = 1'b0;
	logic                    arst_n = 1'b0;
	logic                    in_valid = 1'b0;
	logic                    in_stall;
	logic [ADDRESS_BITS-1:0] dev_address = '0;
	logic [BYTE_W-1:0]       current_byte = '0;
	logic [BYTE_W-1:0]       new_byte = '0;
	logic                    last_byte = 1'b0;
	logic                    out_valid;
	logic                    out_stall = 1'b0;
	logic [SECTOR_W-1:0]     sector_index;
	logic [ACTION_W-1:0]     action;
	logic [PAGE_W-1:0]       first_page;
	logic [COUNT_W-1:0]      page_count;

	byte_item_t  byte_q[$];
	decision_t   decision_q[$];
	byte_item_t  drv_item;
	bit          drv_busy = 1'b0;
	decision_t   got;
	int          src_idle_pct = 0;
	int          snk_stall_pct = 0;
	int          fails = 0;
	int          cycles = 0;

	// planner state mirror
	bit          chunk_live = 1'b0;
	int unsigned chunk_start = 0;
	bit          any_diff = 1'b0;
	bit          needs_erase = 1'b0;

	flash_sector_write_planner u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.dev_address  (dev_address),
		.current_byte (current_byte),
		.new_byte     (new_byte),
		.last_byte    (last_byte),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.sector_index (sector_index),
		.action       (action),
		.first_page   (first_page),
		.page_count   (page_count)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// fold one byte into the open chunk; queue a decision when the chunk closes
	function automatic void plan_byte(input byte_item_t it);
		int unsigned offs, sec, start_off, fp, cnt;
		decision_t   d;
		offs = it.addr % SECTOR_BYTES_DEF;
		if (!chunk_live) begin
			chunk_live  = 1'b1;
			chunk_start = offs;
			any_diff    = 1'b0;
			needs_erase = 1'b0;
		end
		if (it.cur != it.nw) begin
			any_diff = 1'b1;
			// a bit going 0 -> 1 cannot be programmed
			if ((it.cur & it.nw) != it.nw)
				needs_erase = 1'b1;
		end
		if (!it.last && offs != SECTOR_BYTES_DEF - 1)
			return;
		sec = it.addr / SECTOR_BYTES_DEF;
		// address going backward: clamp to a single page
		start_off = (chunk_start > offs) ? offs : chunk_start;
		if (!any_diff) begin
			d.act = ACT_SKIP;
			fp = 0;
			cnt = 0;
		end else if (needs_erase) begin
			d.act = ACT_ERASE;
			fp = sec * PAGES_PER_SECTOR_DEF;
			cnt = PAGES_PER_SECTOR_DEF;
		end else begin
			d.act = ACT_PROGRAM;
			fp = sec * PAGES_PER_SECTOR_DEF + start_off / PAGE_BYTES_DEF;
			cnt = offs / PAGE_BYTES_DEF - start_off / PAGE_BYTES_DEF + 1;
		end
		d.sector = SECTOR_W'(sec);
		d.first  = PAGE_W'(fp);
		d.count  = COUNT_W'(cnt);
		decision_q.push_back(d);
		chunk_live  = 1'b0;
		chunk_start = 0;
		any_diff    = 1'b0;
		needs_erase = 1'b0;
	endfunction

	task automatic push_byte(input int a, input int c, input int n, input bit l);
		byte_item_t it;
		it.addr = ADDRESS_BITS'(a);
		it.cur  = BYTE_W'(c);
		it.nw   = BYTE_W'(n);
		it.last = l;
		byte_q.push_back(it);
	endtask

	// mostly contiguous requests with random content, some loose noise bytes
	task automatic add_requests(input int n_items);
		int added, len, base, mode, i, c, n;
		added = 0;
		while (added < n_items) begin
			if ($urandom_range(0, 9) == 0) begin
				push_byte($urandom, $urandom, $urandom, 1'($urandom_range(0, 1)));
				added++;
			end else begin
				len = ($urandom_range(0, 7) == 0) ? $urandom_range(65, 300)
					: $urandom_range(1, 64);
				case ($urandom_range(0, 2))
					0: base = $urandom_range(0, 131071);
					// start just short of a sector end to cross the boundary
					1: base = $urandom_range(0, 7) * SECTOR_BYTES_DEF + SECTOR_BYTES_DEF
						- $urandom_range(1, 40);
					default: base = $urandom_range(0, 1023) * PAGE_BYTES_DEF;
				endcase
				mode = $urandom_range(0, 2);
				for (i = 0; i < len; i++) begin
					c = $urandom_range(0, 255);
					case (mode)
						0: n = c;
						1: n = ($urandom_range(0, 15) == 0) ? (c & $urandom_range(0, 255)) : c;
						default: n = ($urandom_range(0, 15) == 0) ? $urandom_range(0, 255) : c;
					endcase
					push_byte(base + i, c, n, i == len - 1);
				end
				added += len;
			end
		end
		// close whatever chunk is still open
		push_byte($urandom, $urandom, $urandom, 1'b1);
	endtask

	// byte transaction driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid     <= 1'b0;
			dev_address  <= '0;
			current_byte <= '0;
			new_byte     <= '0;
			last_byte    <= 1'b0;
			drv_busy = 1'b0;
		end else begin
			if (in_valid && !in_stall) begin
				plan_byte(drv_item);
				drv_busy = 1'b0;
			end
			if (!in_valid || !in_stall) begin
				if (byte_q.size() != 0 && $urandom_range(0, 99) >= src_idle_pct) begin
					drv_item = byte_q.pop_front();
					drv_busy = 1'b1;
					in_valid     <= 1'b1;
					dev_address  <= drv_item.addr;
					current_byte <= drv_item.cur;
					new_byte     <= drv_item.nw;
					last_byte    <= drv_item.last;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// decision receiver stall
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else begin
			out_stall <= ($urandom_range(0, 99) < snk_stall_pct);
		end
	end

	// decision monitor
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (decision_q.size() == 0) begin
				$error("unexpected decision: sector_index %0d action %0d %s %0d %s %0d",
					sector_index, action, "first_page", first_page,
					"page_count", page_count);
				fails++;
			end else begin
				got = decision_q.pop_front();
				if (sector_index !== got.sector) begin
					$error("sector_index: expected %0d, actual %0d", got.sector, sector_index);
					fails++;
				end
				if (action !== got.act) begin
					$error("action: expected %0d, actual %0d", got.act, action);
					fails++;
				end
				if (first_page !== got.first) begin
					$error("first_page: expected %0d, actual %0d", got.first, first_page);
					fails++;
				end
				if (page_count !== got.count) begin
					$error("page_count: expected %0d, actual %0d", got.count, page_count);
					fails++;
				end
			end
		end
	end

	// run limit
	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	// stimulus phases
	initial begin
		int ph;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		for (ph = 0; ph < 3; ph++) begin
			case (ph)
				0: begin
					src_idle_pct = 28;
					snk_stall_pct = 62;
				end
				1: begin
					src_idle_pct = 62;
					snk_stall_pct = 28;
				end
				default: begin
					src_idle_pct = 0;
					snk_stall_pct = 0;
				end
			endcase
			if (ph == 0) begin
				// single byte, page 0 program; all bits 1 -> 0
				push_byte(0, 'hFF, 'h00, 1'b1);
				// top address, all bits 0 -> 1: erase sector 7
				push_byte(131071, 'h00, 'hFF, 1'b1);
				// chunk closed by the sector end alone, nothing changed
				push_byte(16383, 'h5A, 'h5A, 1'b0);
				push_byte(131072 - 128, 'hFF, 'hFF, 1'b1);
				// program across three pages
				push_byte(16384 + 100, 'hAA, 'hAA, 1'b0);
				push_byte(16384 + 300, 'hF0, 'h30, 1'b1);
				// address going backward: start clamped
				push_byte(32768 + 1000, 'h0F, 'h0F, 1'b0);
				push_byte(32768 + 200, 'h0F, 'h0E, 1'b1);
				// sector change inside a chunk, backward offset
				push_byte(3 * 16384 + 16000, 'h00, 'h00, 1'b0);
				push_byte(5 * 16384 + 10, 'h80, 'h00, 1'b1);
				// sector change inside a chunk, forward offset
				push_byte(3 * 16384 + 5, 'h00, 'h00, 1'b0);
				push_byte(6 * 16384 + 9000, 'h01, 'h00, 1'b1);
				// erase closed by the sector end
				push_byte(4 * 16384 + 16382, 'h00, 'h00, 1'b0);
				push_byte(4 * 16384 + 16383, 'h00, 'h01, 1'b0);
				// page boundary crossing
				push_byte(2 * 16384 + 127, 'h7F, 'h7F, 1'b0);
				push_byte(2 * 16384 + 128, 'hFF, 'hFE, 1'b1);
			end
			add_requests((ph == 2) ? 650 : 600);
			// hold off new bytes until every decision is back
			@(negedge clk);
			while (byte_q.size() != 0 || drv_busy || decision_q.size() != 0)
				@(negedge clk);
		end
		repeat (DRAIN_CYCLES) @(negedge clk);
		if (fails == 0 && decision_q.size() == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
